/* src/ore_pkg.sv */
// Shared types, constants and the counter adaptation function for the
// order-1 binary context range encoder. No dependencies.
package ore_pkg;

  localparam int SYMBOL_BITS  = 9;
  localparam int INDEX_BITS   = 7;
  localparam int CONTEXT_BITS = 8;
  localparam int MAX_RESULTS  = 24;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

  localparam int RANGE_W    = 32;
  localparam int PROB_W     = 17;
  localparam int PROD_W     = RANGE_W + PROB_W;
  localparam int HALF_W     = 16;
  localparam int CTR_W      = 2 * HALF_W;
  localparam int FAST_SHIFT = 3;
  localparam int SLOW_SHIFT = 6;

  localparam logic [CTR_W-1:0]  COUNTER_INIT = 32'h8000_8000;
  localparam logic [PROB_W-1:0] PROB_HALF    = 17'h1_0000;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_RAW    = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [7:0]  context_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_APPLY,
    ST_RENORM,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RNG_HOLD,
    RNG_MUL,
    RNG_APPLY,
    RNG_SHIFT,
    RNG_FLUSH_SHIFT,
    RNG_RESET
  } rng_op_e;

  typedef struct packed {
    rng_op_e op;
    logic    bit_val;
  } rng_ctrl_t;

  typedef struct packed {
    logic       renorm;
    logic [7:0] top_byte;
  } rng_stat_t;

  typedef struct packed {
    logic start;
    logic emit;
    logic done;
  } emit_ctrl_t;

  typedef struct packed {
    logic emit_ok;
    logic done_ok;
  } stage_stat_t;

  // counter layout: {slow, fast}
  function automatic logic [CTR_W-1:0] counter_update(input logic [CTR_W-1:0] c,
                                                      input logic b);
    logic [HALF_W-1:0] f;
    logic [HALF_W-1:0] s;
    f = c[HALF_W-1:0];
    s = c[CTR_W-1:HALF_W];
    if (b) begin
      f = f + ((~f) >> FAST_SHIFT);
      s = s + ((~s) >> SLOW_SHIFT);
    end else begin
      f = f - (f >> FAST_SHIFT);
      s = s - (s >> SLOW_SHIFT);
    end
    return {s, f};
  endfunction

endpackage

/* src/ore_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ore_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ore_range_unit.sv */
// Range interval registers with the shared 32x17 multiplier, bit apply and
// byte shift logic. Depends on ore_pkg.
module ore_range_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ore_pkg::rng_ctrl_t               ctrl_i,
  input  logic [ore_pkg::PROB_W-1:0]       prob_i,
  output ore_pkg::rng_stat_t               stat_o
);

  logic [ore_pkg::RANGE_W-1:0] low_q, low_d;
  logic [ore_pkg::RANGE_W-1:0] high_q, high_d;
  logic [ore_pkg::RANGE_W-1:0] quot_q, quot_d;
  logic [ore_pkg::RANGE_W-1:0] span;
  logic [ore_pkg::RANGE_W-1:0] mid;
  logic [ore_pkg::PROD_W-1:0]  prod;

  always_comb begin
    span   = high_q - low_q;
    prod   = ore_pkg::PROD_W'(span) * ore_pkg::PROD_W'(prob_i);
    mid    = low_q + quot_q;
    low_d  = low_q;
    high_d = high_q;
    quot_d = quot_q;
    unique case (ctrl_i.op)
      ore_pkg::RNG_HOLD: ;
      ore_pkg::RNG_MUL: begin
        quot_d = prod[ore_pkg::PROD_W-1:ore_pkg::PROB_W];
      end
      ore_pkg::RNG_APPLY: begin
        if (ctrl_i.bit_val) begin
          high_d = mid;
        end else begin
          low_d = mid + 32'd1;
        end
      end
      ore_pkg::RNG_SHIFT: begin
        low_d  = {low_q[23:0], 8'h00};
        high_d = {high_q[23:0], 8'hFF};
      end
      ore_pkg::RNG_FLUSH_SHIFT: begin
        low_d = {low_q[23:0], 8'h00};
      end
      ore_pkg::RNG_RESET: begin
        low_d  = '0;
        high_d = '1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '1;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign stat_o.renorm   = (low_q[31:24] == high_q[31:24]);
  assign stat_o.top_byte = low_q[31:24];

endmodule

/* src/ore_ctrl.sv */
// Sequencer: counter table clearing sweep, per-item bit walk, tree node and
// counter table access, range unit control. Depends on ore_pkg.
module ore_ctrl #(
  parameter int SYMBOL_BITS  = ore_pkg::SYMBOL_BITS,
  parameter int INDEX_BITS   = ore_pkg::INDEX_BITS,
  parameter int CONTEXT_BITS = ore_pkg::CONTEXT_BITS,
  localparam int SYM_AW = CONTEXT_BITS + SYMBOL_BITS,
  localparam int IDX_AW = CONTEXT_BITS + INDEX_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  ore_pkg::in_item_t              in_item_i,
  output logic                           in_ready_o,
  input  ore_pkg::rng_stat_t             rng_stat_i,
  output ore_pkg::rng_ctrl_t             rng_ctrl_o,
  output logic [ore_pkg::PROB_W-1:0]     prob_o,
  input  ore_pkg::stage_stat_t           stage_i,
  output ore_pkg::emit_ctrl_t            emit_o,
  output logic                           sym_we_o,
  output logic [SYM_AW-1:0]              sym_waddr_o,
  output logic [SYM_AW-1:0]              sym_raddr_o,
  input  logic [ore_pkg::CTR_W-1:0]      sym_rdata_i,
  output logic                           idx_we_o,
  output logic [IDX_AW-1:0]              idx_waddr_o,
  output logic [IDX_AW-1:0]              idx_raddr_o,
  input  logic [ore_pkg::CTR_W-1:0]      idx_rdata_i,
  output logic [ore_pkg::CTR_W-1:0]      ctr_wdata_o
);

  localparam int NODE_W = (SYMBOL_BITS > INDEX_BITS) ? SYMBOL_BITS : INDEX_BITS;
  localparam int CLR_W  = CONTEXT_BITS + NODE_W;

  ore_pkg::state_e state_q, state_d;
  ore_pkg::kind_e  kind_q, kind_d;
  logic [31:0]             value_q, value_d;
  logic [CONTEXT_BITS-1:0] ctx_q, ctx_d;
  logic [NODE_W-1:0]       node_q, node_d;
  logic [4:0]              bit_idx_q, bit_idx_d;
  logic [1:0]              flush_q, flush_d;
  logic [CLR_W-1:0]        clr_q, clr_d;

  logic                       bit_val;
  logic [ore_pkg::CTR_W-1:0]  ctr_rd;
  logic [ore_pkg::CTR_W-1:0]  ctr_upd;
  logic                       accept;

  assign accept  = in_valid_i && (state_q == ore_pkg::ST_IDLE);
  assign bit_val = value_q[bit_idx_q];
  assign ctr_rd  = (kind_q == ore_pkg::KIND_INDEX) ? idx_rdata_i : sym_rdata_i;
  assign ctr_upd = ore_pkg::counter_update(ctr_rd, bit_val);

  assign sym_raddr_o = {ctx_q, node_q[SYMBOL_BITS-1:0]};
  assign idx_raddr_o = {ctx_q, node_q[INDEX_BITS-1:0]};

  always_comb begin
    if (kind_q == ore_pkg::KIND_RAW) begin
      prob_o = ore_pkg::PROB_HALF;
    end else begin
      prob_o = ore_pkg::PROB_W'(ctr_rd[ore_pkg::HALF_W-1:0])
             + ore_pkg::PROB_W'(ctr_rd[ore_pkg::CTR_W-1:ore_pkg::HALF_W]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ore_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = ore_pkg::ST_IDLE;
      end
      ore_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.kind)
            ore_pkg::KIND_FLUSH: state_d = ore_pkg::ST_FLUSH;
            ore_pkg::KIND_RAW:   state_d = ore_pkg::ST_MUL;
            default:             state_d = ore_pkg::ST_READ;
          endcase
        end
      end
      ore_pkg::ST_READ:  state_d = ore_pkg::ST_MUL;
      ore_pkg::ST_MUL:   state_d = ore_pkg::ST_APPLY;
      ore_pkg::ST_APPLY: state_d = ore_pkg::ST_RENORM;
      ore_pkg::ST_RENORM: begin
        if (!rng_stat_i.renorm) begin
          state_d = (bit_idx_q == 5'd0) ? ore_pkg::ST_DONE : ore_pkg::ST_MUL;
        end
      end
      ore_pkg::ST_FLUSH: begin
        if (stage_i.emit_ok && flush_q == 2'd0) state_d = ore_pkg::ST_DONE;
      end
      ore_pkg::ST_DONE: begin
        if (stage_i.done_ok) state_d = ore_pkg::ST_IDLE;
      end
      default: state_d = ore_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o         = 1'b0;
    rng_ctrl_o.op      = ore_pkg::RNG_HOLD;
    rng_ctrl_o.bit_val = bit_val;
    emit_o             = '0;
    sym_we_o           = 1'b0;
    idx_we_o           = 1'b0;
    sym_waddr_o        = sym_raddr_o;
    idx_waddr_o        = idx_raddr_o;
    ctr_wdata_o        = ctr_upd;
    unique case (state_q)
      ore_pkg::ST_CLEAR: begin
        sym_we_o    = 1'b1;
        idx_we_o    = 1'b1;
        sym_waddr_o = clr_q[SYM_AW-1:0];
        idx_waddr_o = clr_q[IDX_AW-1:0];
        ctr_wdata_o = ore_pkg::COUNTER_INIT;
      end
      ore_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        emit_o.start = in_valid_i;
      end
      ore_pkg::ST_READ: ;
      ore_pkg::ST_MUL: begin
        rng_ctrl_o.op = ore_pkg::RNG_MUL;
        sym_we_o      = (kind_q == ore_pkg::KIND_SYMBOL);
        idx_we_o      = (kind_q == ore_pkg::KIND_INDEX);
      end
      ore_pkg::ST_APPLY: rng_ctrl_o.op = ore_pkg::RNG_APPLY;
      ore_pkg::ST_RENORM: begin
        if (rng_stat_i.renorm && stage_i.emit_ok) begin
          rng_ctrl_o.op = ore_pkg::RNG_SHIFT;
          emit_o.emit   = 1'b1;
        end
      end
      ore_pkg::ST_FLUSH: begin
        if (stage_i.emit_ok) begin
          rng_ctrl_o.op = (flush_q == 2'd0) ? ore_pkg::RNG_RESET : ore_pkg::RNG_FLUSH_SHIFT;
          emit_o.emit   = 1'b1;
        end
      end
      ore_pkg::ST_DONE: emit_o.done = stage_i.done_ok;
      default: ;
    endcase
  end

  // item and sequencing registers
  always_comb begin
    kind_d    = kind_q;
    value_d   = value_q;
    ctx_d     = ctx_q;
    node_d    = node_q;
    bit_idx_d = bit_idx_q;
    flush_d   = flush_q;
    clr_d     = clr_q;
    if (state_q == ore_pkg::ST_CLEAR) begin
      clr_d = clr_q + 1'b1;
    end
    if (accept) begin
      kind_d  = in_item_i.kind;
      value_d = in_item_i.value;
      ctx_d   = in_item_i.context_req[CONTEXT_BITS-1:0];
      node_d  = NODE_W'(1);
      flush_d = 2'd3;
      case (in_item_i.kind)
        ore_pkg::KIND_SYMBOL: bit_idx_d = 5'(SYMBOL_BITS - 1);
        ore_pkg::KIND_INDEX:  bit_idx_d = 5'(INDEX_BITS - 1);
        default:              bit_idx_d = 5'd31;
      endcase
    end
    if (state_q == ore_pkg::ST_APPLY) begin
      node_d = {node_q[NODE_W-2:0], bit_val};
    end
    if (state_q == ore_pkg::ST_RENORM && !rng_stat_i.renorm && bit_idx_q != 5'd0) begin
      bit_idx_d = bit_idx_q - 5'd1;
    end
    if (state_q == ore_pkg::ST_FLUSH && stage_i.emit_ok) begin
      flush_d = flush_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ore_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    value_q   <= value_d;
    ctx_q     <= ctx_d;
    node_q    <= node_d;
    bit_idx_q <= bit_idx_d;
    flush_q   <= flush_d;
  end

endmodule

/* src/order1_binary_context_range_encoder.sv */
// Top level of the order-1 binary context range encoder: sequencer, range
// unit, two counter RAMs and the output byte staging.
// Depends on ore_pkg, ore_ram, ore_range_unit, ore_ctrl.
//
// Input channel (in_valid_i/in_ready_o, in_item_i): one transfer per item,
// kind 0 codes a symbol through the symbol counter tree, kind 1 a match
// index through the index tree, kind 2 a raw 32-bit word, kind 3 flushes.
// Output channel (out_valid_o/out_ready_i, out_item_o): one transfer per
// compressed byte; last marks the final byte of an item.
// One item is worked at a time; in_ready_o is low until all its bytes are
// handed to the output register. Each coded bit goes through multiply, apply
// and renormalize check on the shared 32x17 multiplier path, with one more
// shift step per emitted byte; a symbol or an index first reads its counter
// from the counter RAM, and a raw word skips that read.
// A byte is held back one step so its last flag is known; at most one byte
// sits in the output register, and a receiver stall stops the sequencer.
// After reset both counter RAMs are swept to their initial value, one entry
// per cycle over 2^(CONTEXT_BITS + max(SYMBOL_BITS, INDEX_BITS)) addresses
// (131072 by default), while in_ready_o stays low.
module order1_binary_context_range_encoder #(
  parameter int SYMBOL_BITS  = ore_pkg::SYMBOL_BITS,
  parameter int INDEX_BITS   = ore_pkg::INDEX_BITS,
  parameter int CONTEXT_BITS = ore_pkg::CONTEXT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ore_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ore_pkg::out_item_t out_item_o
);

  localparam int SYM_AW = CONTEXT_BITS + SYMBOL_BITS;
  localparam int IDX_AW = CONTEXT_BITS + INDEX_BITS;

  ore_pkg::rng_ctrl_t   rng_ctrl;
  ore_pkg::rng_stat_t   rng_stat;
  ore_pkg::emit_ctrl_t  emit;
  ore_pkg::stage_stat_t stage;
  logic [ore_pkg::PROB_W-1:0] prob;

  logic                      sym_we, idx_we;
  logic [SYM_AW-1:0]         sym_waddr, sym_raddr;
  logic [IDX_AW-1:0]         idx_waddr, idx_raddr;
  logic [ore_pkg::CTR_W-1:0] sym_rdata, idx_rdata, ctr_wdata;

  ore_ctrl #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .CONTEXT_BITS(CONTEXT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .rng_stat_i (rng_stat),
    .rng_ctrl_o (rng_ctrl),
    .prob_o     (prob),
    .stage_i    (stage),
    .emit_o     (emit),
    .sym_we_o   (sym_we),
    .sym_waddr_o(sym_waddr),
    .sym_raddr_o(sym_raddr),
    .sym_rdata_i(sym_rdata),
    .idx_we_o   (idx_we),
    .idx_waddr_o(idx_waddr),
    .idx_raddr_o(idx_raddr),
    .idx_rdata_i(idx_rdata),
    .ctr_wdata_o(ctr_wdata)
  );

  ore_range_unit u_range (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(rng_ctrl),
    .prob_i(prob),
    .stat_o(rng_stat)
  );

  ore_ram #(
    .WIDTH(ore_pkg::CTR_W),
    .DEPTH(1 << SYM_AW)
  ) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (sym_we),
    .waddr_i(sym_waddr),
    .wdata_i(ctr_wdata),
    .raddr_i(sym_raddr),
    .rdata_o(sym_rdata)
  );

  ore_ram #(
    .WIDTH(ore_pkg::CTR_W),
    .DEPTH(1 << IDX_AW)
  ) u_idx_ram (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .waddr_i(idx_waddr),
    .wdata_i(ctr_wdata),
    .raddr_i(idx_raddr),
    .rdata_o(idx_rdata)
  );

  // output staging: pending byte plus output register
  logic                      pend_q, pend_d;
  logic [7:0]                pend_byte_q, pend_byte_d;
  logic                      out_valid_q, out_valid_d;
  ore_pkg::out_item_t        out_q, out_d;
  logic [ore_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      out_free;
  logic                      drop;

  assign out_free      = !out_valid_q || out_ready_i;
  assign drop          = (cnt_q >= ore_pkg::CNT_W'(ore_pkg::MAX_RESULTS));
  assign stage.emit_ok = drop || !pend_q || out_free;
  assign stage.done_ok = !pend_q || out_free;

  always_comb begin
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cnt_d       = cnt_q;
    if (emit.start) begin
      cnt_d = '0;
    end
    if (emit.emit && !drop) begin
      cnt_d       = cnt_q + 1'b1;
      pend_d      = 1'b1;
      pend_byte_d = rng_stat.top_byte;
      if (pend_q) begin
        out_valid_d    = 1'b1;
        out_d.out_byte = pend_byte_q;
        out_d.last     = 1'b0;
      end
    end
    if (emit.done && pend_q) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = pend_byte_q;
      out_d.last     = 1'b1;
      pend_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* bench/tb.sv */
// Testbench for order1_binary_context_range_encoder: random and directed items
// with a bit-exact prediction of the compressed byte stream and of the last flags.
// Depends on ore_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int SYM_N = 1 << (ore_pkg::CONTEXT_BITS + ore_pkg::SYMBOL_BITS);
  localparam int IDX_N = 1 << (ore_pkg::CONTEXT_BITS + ore_pkg::INDEX_BITS);
  localparam logic [7:0] CTX_MASK = 8'((1 << ore_pkg::CONTEXT_BITS) - 1);
  localparam int RANDOM_ITEMS = 87;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  ore_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  ore_pkg::out_item_t out_item_o;

  int cycle_count = 0;

  class byte_stream_checker;
    bit [31:0] lo;
    bit [31:0] hi;
    bit [15:0] sym_fast [SYM_N];
    bit [15:0] sym_slow [SYM_N];
    bit [15:0] idx_fast [IDX_N];
    bit [15:0] idx_slow [IDX_N];
    ore_pkg::out_item_t item_bytes [$];
    ore_pkg::out_item_t pending_bytes [$];
    int errors;
    int n_items;
    int n_silent;
    int n_bytes;
    int kind_seen [4];

    function new();
      lo = '0;
      hi = '1;
      foreach (sym_fast[i]) begin
        sym_fast[i] = 16'h8000;
        sym_slow[i] = 16'h8000;
      end
      foreach (idx_fast[i]) begin
        idx_fast[i] = 16'h8000;
        idx_slow[i] = 16'h8000;
      end
      errors = 0;
      n_items = 0;
      n_silent = 0;
      n_bytes = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void put_byte(bit [7:0] b);
      ore_pkg::out_item_t o;
      o.out_byte = b;
      o.last = 1'b0;
      if (item_bytes.size() < ore_pkg::MAX_RESULTS) item_bytes.push_back(o);
    endfunction

    function void settle();
      while ((lo ^ hi) < 32'h0100_0000) begin
        put_byte(lo[31:24]);
        lo = lo << 8;
        hi = {hi[23:0], 8'hFF};
      end
    endfunction

    function void code_tree(bit on_index, bit [7:0] ctx, bit [31:0] v, int nbits);
      int unsigned node;
      int unsigned slot;
      bit b;
      bit [15:0] f;
      bit [15:0] s;
      bit [16:0] p;
      bit [63:0] prod;
      bit [31:0] mid;
      node = 1;
      for (int i = nbits - 1; i >= 0; i--) begin
        b = v[i];
        slot = (int'(ctx) << nbits) | node;
        if (on_index) begin
          f = idx_fast[slot];
          s = idx_slow[slot];
        end else begin
          f = sym_fast[slot];
          s = sym_slow[slot];
        end
        p = {1'b0, f} + {1'b0, s};
        prod = {32'b0, hi - lo} * {47'b0, p};
        mid = lo + prod[48:17];
        if (b) begin
          f = f + (~f >> 3);
          s = s + (~s >> 6);
          hi = mid;
        end else begin
          f = f - (f >> 3);
          s = s - (s >> 6);
          lo = mid + 1;
        end
        if (on_index) begin
          idx_fast[slot] = f;
          idx_slow[slot] = s;
        end else begin
          sym_fast[slot] = f;
          sym_slow[slot] = s;
        end
        settle();
        node = (node << 1) | b;
      end
    endfunction

    function void code_raw(bit [31:0] v);
      bit [31:0] mid;
      for (int i = 31; i >= 0; i--) begin
        mid = lo + ((hi - lo) >> 1);
        if (v[i]) hi = mid;
        else lo = mid + 1;
        settle();
      end
    endfunction

    // accepted input transfer: predict its bytes
    function void code_item(ore_pkg::in_item_t it);
      item_bytes.delete();
      case (it.kind)
        ore_pkg::KIND_SYMBOL:
          code_tree(1'b0, it.context_req & CTX_MASK, it.value, ore_pkg::SYMBOL_BITS);
        ore_pkg::KIND_INDEX:
          code_tree(1'b1, it.context_req & CTX_MASK, it.value, ore_pkg::INDEX_BITS);
        ore_pkg::KIND_RAW: code_raw(it.value);
        default: begin
          for (int i = 0; i < 4; i++) begin
            put_byte(lo[31:24]);
            lo = lo << 8;
          end
          lo = '0;
          hi = '1;
        end
      endcase
      if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
      else n_silent++;
      foreach (item_bytes[i]) pending_bytes.push_back(item_bytes[i]);
      n_items++;
      kind_seen[int'(it.kind)]++;
    endfunction

    // accepted output transfer
    function void match_byte(ore_pkg::out_item_t got);
      ore_pkg::out_item_t want;
      n_bytes++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, got.out_byte, got.last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  byte_stream_checker stream = new();

  order1_binary_context_range_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run still busy after %0d cycles", $time, CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit quiet_window();
    return stream.n_items >= 30 && stream.n_items < 55;
  endfunction

  function automatic ore_pkg::in_item_t mk(ore_pkg::kind_e k, logic [31:0] v,
                                           logic [7:0] c);
    ore_pkg::in_item_t it;
    it.kind = k;
    it.value = v;
    it.context_req = c;
    return it;
  endfunction

  function automatic ore_pkg::in_item_t random_item();
    ore_pkg::in_item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.value = $urandom();
    it.context_req = 8'($urandom_range(255));
    if (r < 45) begin
      it.kind = ore_pkg::KIND_SYMBOL;
      if ($urandom_range(1) == 1) begin
        it.value[8:0] = 9'(97 + 3 * $urandom_range(3));
        it.context_req = 8'($urandom_range(3));
      end
    end else if (r < 70) begin
      it.kind = ore_pkg::KIND_INDEX;
      if ($urandom_range(1) == 1) begin
        it.value[6:0] = 7'($urandom_range(3));
        it.context_req = 8'($urandom_range(3));
      end
    end else if (r < 90) begin
      it.kind = ore_pkg::KIND_RAW;
    end else begin
      it.kind = ore_pkg::KIND_FLUSH;
    end
    return it;
  endfunction

  task automatic drive_item(ore_pkg::in_item_t it);
    if (!quiet_window() && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    stream.code_item(it);
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stream.match_byte(out_item_o);
      if (!hold_used && stream.n_items >= 60) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (quiet_window()) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // flush of the untouched interval, field extremes, ignored upper value bits
    drive_item(mk(ore_pkg::KIND_FLUSH, 32'h0, 8'h00));
    drive_item(mk(ore_pkg::KIND_SYMBOL, 32'h0, 8'h00));
    drive_item(mk(ore_pkg::KIND_SYMBOL, 32'h1FF, 8'hFF));
    drive_item(mk(ore_pkg::KIND_SYMBOL, 32'hFFFF_FF55, 8'hAA));
    drive_item(mk(ore_pkg::KIND_INDEX, 32'h0, 8'h00));
    drive_item(mk(ore_pkg::KIND_INDEX, 32'h7F, 8'hFF));
    drive_item(mk(ore_pkg::KIND_INDEX, 32'hFFFF_FFAA, 8'h55));
    drive_item(mk(ore_pkg::KIND_RAW, 32'h0, 8'h00));
    drive_item(mk(ore_pkg::KIND_RAW, 32'hFFFF_FFFF, 8'hFF));
    drive_item(mk(ore_pkg::KIND_RAW, 32'hA5A5_5A5A, 8'h3C));
    drive_item(mk(ore_pkg::KIND_FLUSH, 32'hFFFF_FFFF, 8'hFF));
    // skewed counters, items that end up emitting nothing
    repeat (8) drive_item(mk(ore_pkg::KIND_SYMBOL, 32'h0, 8'h07));
    repeat (3) drive_item(mk(ore_pkg::KIND_INDEX, 32'h55, 8'h07));
    drive_item(mk(ore_pkg::KIND_FLUSH, 32'h1234_5678, 8'h07));

    for (int n = 0; n < RANDOM_ITEMS; n++) drive_item(random_item());
    in_valid_i <= 1'b0;

    while (stream.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Coded %0d items: %0d symbols, %0d indexes, %0d raw words, %0d flushes",
             stream.n_items, stream.kind_seen[ore_pkg::KIND_SYMBOL],
             stream.kind_seen[ore_pkg::KIND_INDEX],
             stream.kind_seen[ore_pkg::KIND_RAW], stream.kind_seen[ore_pkg::KIND_FLUSH]);
    $display("%0d compressed bytes compared, %0d items produced no byte, %0d errors",
             stream.n_bytes, stream.n_silent, stream.errors);
    if (stream.errors == 0 && stream.pending_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ore_pkg.sv
src/ore_ram.sv
src/ore_range_unit.sv
src/ore_ctrl.sv
src/order1_binary_context_range_encoder.sv
bench/tb.sv
